@@ rtl/core/frame_stack_deferred_release_unit_assert.svh @@
// Assertion macros for the frame stack deferred release unit.
// Included by the RTL modules that carry concurrent checks; no dependencies.
`ifndef FRAME_STACK_DEFERRED_RELEASE_UNIT_ASSERT_SVH
`define FRAME_STACK_DEFERRED_RELEASE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define FSDR_ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame stack: assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define FSDR_ASSERT_NEVER(label, clk, rst_n, cond) \
  `FSDR_ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define FSDR_ASSERT_PROP(label, clk, rst_n, prop)

`define FSDR_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/fsdr_pkg.sv @@
// Shared types, codes and defaults for the frame stack deferred release unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package fsdr_pkg;

  // Default sizing of the slot memory and the frame tables.
  localparam int SLOT_COUNT_DEF  = 1024;
  localparam int FRAME_COUNT_DEF = 256;
  localparam int EXPR_WIDTH_DEF  = 32;

  // Fixed widths of the item fields.
  localparam int REQ_W    = 2;
  localparam int FSIZE_W  = 11;
  localparam int SIDX_W   = 10;
  localparam int SEXPR_W  = 32;
  localparam int LINK_W   = 10;
  localparam int FIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int BASE_W   = 10;
  localparam int TSIZE_W  = 11;
  localparam int TFRAME_W = 8;
  localparam int USED_W   = 11;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY_PUSH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STACK_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FSIZE_W-1:0] claim_size;
    logic [SIDX_W-1:0]  slot_index;
    logic [SEXPR_W-1:0] slot_expr;
    logic [LINK_W-1:0]  slot_link;
    logic [FIDX_W-1:0]  frame_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                stack_empty;
    logic [BASE_W-1:0]   base_offset;
    logic [TSIZE_W-1:0]  top_frame_size;
    logic [TFRAME_W-1:0] top_frame;
    logic [USED_W-1:0]   used_slots;
    logic [SEXPR_W-1:0]  read_expr;
    logic [LINK_W-1:0]   read_link;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch_req;
    logic                clr_init;
    logic                clr_step;
    logic                push_commit;
    logic                slot_access;
    logic                rel_read;
    logic                rel_write;
    logic                pop_top;
    logic                pop_read;
    logic                pop_pop;
    logic                pop_stop;
    logic                pop_empty;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                finish;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             size_zero;
    logic             push_full;
    logic             stack_empty;
    logic             slot_bad;
    logic             frame_bad;
    logic             frame_is_top;
    logic             uses_zero;
    logic             uses_one;
    logic             clr_last;
  } flags_t;

endpackage

`default_nettype wire

@@ rtl/core/fsdr_ctrl.sv @@
// Sequencing controller of the frame stack deferred release unit.
// Depends on fsdr_pkg; drives the datapath through cmd_t and reads flags_t.
`default_nettype none

module fsdr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire fsdr_pkg::flags_t flags_i,
  output fsdr_pkg::cmd_t       cmd_o
);
  import fsdr_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_CLEAR    = 3'd2;
  localparam logic [2:0] S_REL_EVAL = 3'd3;
  localparam logic [2:0] S_POP_READ = 3'd4;
  localparam logic [2:0] S_POP_EVAL = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (flags_i.req_type)
          REQ_PUSH: begin
            if (flags_i.size_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY_PUSH;
            end else if (flags_i.push_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.clr_init = 1'b1;
              state_d        = S_CLEAR;
            end
          end
          REQ_RELEASE: begin
            if (flags_i.stack_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_STACK_EMPTY;
            end else if (flags_i.frame_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_INDEX;
            end else begin
              cmd_o.rel_read = 1'b1;
              state_d        = S_REL_EVAL;
            end
          end
          default: begin
            // store and read share the checks and the slot port
            if (flags_i.stack_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_STACK_EMPTY;
            end else if (flags_i.slot_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_INDEX;
            end else begin
              cmd_o.slot_access = 1'b1;
            end
          end
        endcase
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (flags_i.clr_last) begin
          cmd_o.push_commit = 1'b1;
          state_d           = S_FINISH;
        end
      end
      S_REL_EVAL: begin
        state_d = S_FINISH;
        if (flags_i.uses_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_RELEASED;
        end else begin
          cmd_o.rel_write = 1'b1;
          // top frame count reaches zero: start the cascade
          if (flags_i.frame_is_top && flags_i.uses_one) begin
            cmd_o.pop_top = 1'b1;
            state_d       = S_POP_READ;
          end
        end
      end
      S_POP_READ: begin
        if (flags_i.stack_empty) begin
          cmd_o.pop_empty = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = S_POP_EVAL;
        end
      end
      S_POP_EVAL: begin
        if (flags_i.uses_zero) begin
          cmd_o.pop_pop = 1'b1;
          state_d       = S_POP_READ;
        end else begin
          cmd_o.pop_stop = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/fsdr_datapath.sv @@
// Datapath of the frame stack deferred release unit: slot memories, frame
// tables, stack registers and the result register. Depends on fsdr_pkg.
`default_nettype none
`include "frame_stack_deferred_release_unit_assert.svh"

module fsdr_datapath #(
  parameter int SLOT_COUNT  = fsdr_pkg::SLOT_COUNT_DEF,
  parameter int FRAME_COUNT = fsdr_pkg::FRAME_COUNT_DEF,
  parameter int EXPR_WIDTH  = fsdr_pkg::EXPR_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fsdr_pkg::req_t   req_i,
  input  wire fsdr_pkg::cmd_t   cmd_i,
  output fsdr_pkg::flags_t      flags_o,
  output logic                  done_o,
  output fsdr_pkg::rsp_t        rsp_o
);
  import fsdr_pkg::*;

  localparam int AW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int SW  = (CW > FSIZE_W) ? CW : FSIZE_W;
  localparam int FAW = $clog2(FRAME_COUNT);
  localparam int DW  = $clog2(FRAME_COUNT + 1);
  localparam int FW  = (DW > FIDX_W) ? DW : FIDX_W;

  localparam logic [CW-1:0] SLOT_TOTAL = CW'(SLOT_COUNT);
  localparam logic [DW-1:0] DEPTH_MAX  = DW'(FRAME_COUNT);

  // Memories; contents undefined until written.
  logic [EXPR_WIDTH-1:0] expr_mem [SLOT_COUNT];
  logic [LINK_W-1:0]     link_mem [SLOT_COUNT];
  logic [CW-1:0]         size_mem [FRAME_COUNT];
  logic [CW-1:0]         uses_mem [FRAME_COUNT];

  // Control state.
  logic [DW-1:0]       depth_q;
  logic [CW-1:0]       used_q;
  logic [AW-1:0]       top_base_q;
  logic [CW-1:0]       top_size_q;
  logic [STATUS_W-1:0] status_q;
  logic                done_q;

  // Payload registers.
  req_t                  req_q;
  logic [CW-1:0]         clr_q;
  logic [CW-1:0]         clr_end_q;
  logic [CW-1:0]         uses_rd_q;
  logic [CW-1:0]         size_rd_q;
  logic [EXPR_WIDTH-1:0] expr_rd_q;
  logic [LINK_W-1:0]     link_rd_q;
  rsp_t                  rsp_q;

  logic [SW-1:0]  size_ext;
  logic [SW-1:0]  free_ext;
  logic [SW-1:0]  sidx_ext;
  logic [AW-1:0]  slot_addr;
  logic [FW-1:0]  fidx_ext;
  logic [FAW-1:0] fidx_addr;
  logic [DW-1:0]  depth_m1;
  logic [FAW-1:0] top_idx;
  logic [FAW-1:0] uses_rd_idx;
  logic [CW-1:0]  clr_nxt;
  logic [CW-1:0]  base_after;
  logic           empty;
  logic           read_ok;
  rsp_t           rsp_d;

  assign size_ext    = SW'(req_q.claim_size);
  assign free_ext    = SW'(SLOT_TOTAL - used_q);
  assign sidx_ext    = SW'(req_q.slot_index);
  assign slot_addr   = top_base_q + sidx_ext[AW-1:0];
  assign fidx_ext    = FW'(req_q.frame_index);
  assign fidx_addr   = fidx_ext[FAW-1:0];
  assign depth_m1    = depth_q - DW'(1);
  assign top_idx     = depth_m1[FAW-1:0];
  assign uses_rd_idx = cmd_i.rel_read ? fidx_addr : top_idx;
  assign clr_nxt     = clr_q + CW'(1);
  assign base_after  = used_q - size_rd_q;
  assign empty       = (depth_q == '0);

  always_comb begin
    flags_o.req_type     = req_q.req_type;
    flags_o.size_zero    = (req_q.claim_size == '0);
    flags_o.push_full    = (depth_q >= DEPTH_MAX) || (size_ext > free_ext);
    flags_o.stack_empty  = empty;
    flags_o.slot_bad     = (sidx_ext >= SW'(top_size_q));
    flags_o.frame_bad    = (fidx_ext >= FW'(depth_q));
    flags_o.frame_is_top = (fidx_ext == FW'(depth_m1));
    flags_o.uses_zero    = (uses_rd_q == '0);
    flags_o.uses_one     = (uses_rd_q == CW'(1));
    flags_o.clr_last     = (clr_nxt == clr_end_q);
  end

  // Slot memories: clear sweep or store on the write port, slot read registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      expr_mem[clr_q[AW-1:0]] <= '0;
      link_mem[clr_q[AW-1:0]] <= '0;
    end else if (cmd_i.slot_access && (req_q.req_type == REQ_STORE)) begin
      expr_mem[slot_addr] <= EXPR_WIDTH'(req_q.slot_expr);
      link_mem[slot_addr] <= req_q.slot_link;
    end
    if (cmd_i.slot_access) begin
      expr_rd_q <= expr_mem[slot_addr];
      link_rd_q <= link_mem[slot_addr];
    end
  end

  // Frame tables: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_commit) begin
      size_mem[depth_q[FAW-1:0]] <= size_ext[CW-1:0];
      uses_mem[depth_q[FAW-1:0]] <= size_ext[CW-1:0];
    end else if (cmd_i.rel_write) begin
      uses_mem[fidx_addr] <= uses_rd_q - CW'(1);
    end
    if (cmd_i.rel_read || cmd_i.pop_read) begin
      uses_rd_q <= uses_mem[uses_rd_idx];
    end
    if (cmd_i.pop_read) begin
      size_rd_q <= size_mem[top_idx];
    end
  end

  always_comb begin
    read_ok              = (req_q.req_type == REQ_READ) && (status_q == ST_OK);
    rsp_d.status         = status_q;
    rsp_d.stack_empty    = empty;
    rsp_d.base_offset    = empty ? '0 : BASE_W'(top_base_q);
    rsp_d.top_frame_size = empty ? '0 : TSIZE_W'(top_size_q);
    rsp_d.top_frame      = empty ? '0 : TFRAME_W'(depth_m1);
    rsp_d.used_slots     = USED_W'(used_q);
    rsp_d.read_expr      = read_ok ? SEXPR_W'(expr_rd_q) : '0;
    rsp_d.read_link      = read_ok ? link_rd_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
    end
    if (cmd_i.clr_init) begin
      clr_q     <= used_q;
      clr_end_q <= used_q + size_ext[CW-1:0];
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_nxt;
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      used_q     <= '0;
      top_base_q <= '0;
      top_size_q <= '0;
      status_q   <= ST_OK;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.latch_req) begin
        status_q <= ST_OK;
      end else if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.push_commit) begin
        top_base_q <= used_q[AW-1:0];
        top_size_q <= size_ext[CW-1:0];
        used_q     <= clr_end_q;
        depth_q    <= depth_q + DW'(1);
      end else if (cmd_i.pop_top) begin
        used_q  <= used_q - top_size_q;
        depth_q <= depth_m1;
      end else if (cmd_i.pop_pop) begin
        used_q     <= used_q - size_rd_q;
        depth_q    <= depth_m1;
        top_size_q <= size_rd_q;
      end else if (cmd_i.pop_stop) begin
        top_size_q <= size_rd_q;
        top_base_q <= base_after[AW-1:0];
      end else if (cmd_i.pop_empty) begin
        top_base_q <= '0;
        top_size_q <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `FSDR_ASSERT_NEVER(a_used_bound, clk_i, rst_ni, used_q > SLOT_TOTAL)
  `FSDR_ASSERT_NEVER(a_empty_clean, clk_i, rst_ni, cmd_i.finish && empty && |(used_q | top_size_q))
  `FSDR_ASSERT_PROP(a_top_fits, clk_i, rst_ni, cmd_i.finish && !empty |-> (CW'(top_base_q) + top_size_q == used_q))
  `FSDR_ASSERT_PROP(a_clear_window, clk_i, rst_ni, cmd_i.clr_step |-> (clr_q < clr_end_q))

endmodule

`default_nettype wire

@@ rtl/core/frame_stack_deferred_release_unit.sv @@
// Frame stack deferred release unit: usage
// Request channel: drive req_i and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the item is
// finished, then drops in the same cycle that the result shows.
// Result channel: done_o is high for exactly one cycle with rsp_o valid; the
// receiver must take it then, there is no backpressure.
// Controller steps from the accepting edge to the result (decode first, finish last):
//   store, read, rejected push, release on an empty stack or bad frame: decode only;
//   push of N slots: a clear sweep of the N slots, one slot cleared per cycle;
//   release that pops nothing, an extra release included: one evaluate step;
//   release that pops the top frame: evaluate, a table read, then a compare unless
//   the stack ends empty; each further frame popped adds one read and one compare.
// One item is in flight at a time: no new item is taken while busy is high.
// Reset clears the stack to empty; slot and frame memories are not cleared
// and need no sweep, as every slot is cleared by the push that claims it.
// Depends on fsdr_pkg, fsdr_ctrl and fsdr_datapath.
`default_nettype none

module frame_stack_deferred_release_unit #(
  parameter int SLOT_COUNT  = fsdr_pkg::SLOT_COUNT_DEF,
  parameter int FRAME_COUNT = fsdr_pkg::FRAME_COUNT_DEF,
  parameter int EXPR_WIDTH  = fsdr_pkg::EXPR_WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fsdr_pkg::req_t req_i,
  output logic                done_o,
  output fsdr_pkg::rsp_t      rsp_o
);
  import fsdr_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  fsdr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .flags_i (flags),
    .cmd_o   (cmd)
  );

  fsdr_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .EXPR_WIDTH  (EXPR_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .flags_o (flags),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_frame_stack_deferred_release_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for frame_stack_deferred_release_unit: directed and random push,
// store, release and read items, each report checked against an in-bench frame stack.
// Depends on fsdr_pkg and the RTL of the unit.
module tb_frame_stack_deferred_release_unit;
  import fsdr_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int FRAMES        = FRAME_COUNT_DEF;
  localparam int RANDOM_ITEMS  = 160;
  localparam int USED_CAP      = 150;
  localparam int STALL_LIMIT   = 10000;
  localparam int SETTLE_CYCLES = 40;
  // Two copies of the stack: one steers the stimulus, one predicts the reports.
  localparam int STEER = 0;
  localparam int CHECK = 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  frame_stack_deferred_release_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [SEXPR_W-1:0] slot_expr_m  [2][SLOTS];
  logic [LINK_W-1:0]  slot_link_m  [2][SLOTS];
  int                 frame_len_m  [2][FRAMES];
  int                 uses_left_m  [2][FRAMES];
  int                 depth_m [2] = '{0, 0};
  int                 used_m  [2] = '{0, 0};
  int                 base_m  [2] = '{0, 0};

  req_t request_queue[$];
  rsp_t awaited_reports[$];
  int   total_items    = 0;
  int   accepted_count = 0;
  int   report_count   = 0;
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  int   idle_pct;
  rsp_t want;

  // Apply one item to stack copy m and return the report it gives.
  function automatic rsp_t advance_stack(input int m, input req_t r);
    rsp_t rep;
    int   sz;
    int   at;
    int   i;
    rep = '0;
    rep.status = ST_OK;
    sz = int'(r.claim_size);
    case (r.req_type)
      REQ_PUSH: begin
        if (sz == 0) begin
          rep.status = ST_EMPTY_PUSH;
        end else if (depth_m[m] >= FRAMES || sz > SLOTS - used_m[m]) begin
          rep.status = ST_FULL;
        end else begin
          for (i = used_m[m]; i < used_m[m] + sz; i++) begin
            slot_expr_m[m][i] = '0;
            slot_link_m[m][i] = '0;
          end
          frame_len_m[m][depth_m[m]] = sz;
          uses_left_m[m][depth_m[m]] = sz;
          base_m[m] = used_m[m];
          used_m[m] += sz;
          depth_m[m]++;
        end
      end
      REQ_RELEASE: begin
        if (depth_m[m] == 0) begin
          rep.status = ST_STACK_EMPTY;
        end else if (int'(r.frame_index) >= depth_m[m]) begin
          rep.status = ST_BAD_INDEX;
        end else if (uses_left_m[m][r.frame_index] == 0) begin
          rep.status = ST_RELEASED;
        end else begin
          uses_left_m[m][r.frame_index]--;
          if (int'(r.frame_index) == depth_m[m] - 1) begin
            // pop every exhausted frame off the top
            while (depth_m[m] > 0 && uses_left_m[m][depth_m[m] - 1] == 0) begin
              depth_m[m]--;
              used_m[m] -= frame_len_m[m][depth_m[m]];
            end
            base_m[m] = (depth_m[m] == 0) ? 0 : used_m[m] - frame_len_m[m][depth_m[m] - 1];
          end
        end
      end
      default: begin
        if (depth_m[m] == 0) begin
          rep.status = ST_STACK_EMPTY;
        end else if (int'(r.slot_index) >= frame_len_m[m][depth_m[m] - 1]) begin
          rep.status = ST_BAD_INDEX;
        end else begin
          at = base_m[m] + int'(r.slot_index);
          if (r.req_type == REQ_STORE) begin
            slot_expr_m[m][at] = r.slot_expr;
            slot_link_m[m][at] = r.slot_link;
          end else begin
            rep.read_expr = slot_expr_m[m][at];
            rep.read_link = slot_link_m[m][at];
          end
        end
      end
    endcase
    rep.stack_empty = (depth_m[m] == 0);
    if (depth_m[m] != 0) begin
      rep.base_offset    = BASE_W'(base_m[m]);
      rep.top_frame_size = TSIZE_W'(frame_len_m[m][depth_m[m] - 1]);
      rep.top_frame      = TFRAME_W'(depth_m[m] - 1);
    end
    rep.used_slots = USED_W'(used_m[m]);
    return rep;
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.req_type    = REQ_READ;
    r.claim_size  = FSIZE_W'($urandom_range(2047));
    r.slot_index  = SIDX_W'($urandom_range(1023));
    r.slot_expr   = $urandom;
    r.slot_link   = LINK_W'($urandom_range(1023));
    r.frame_index = FIDX_W'($urandom_range(255));
    return r;
  endfunction

  task automatic enqueue(input req_t r);
    request_queue.push_back(r);
    void'(advance_stack(STEER, r));
  endtask

  task automatic send_push(input int sz);
    req_t r;
    r = random_fields();
    r.req_type   = REQ_PUSH;
    r.claim_size = FSIZE_W'(sz);
    enqueue(r);
  endtask

  task automatic send_release(input int f);
    req_t r;
    r = random_fields();
    r.req_type    = REQ_RELEASE;
    r.frame_index = FIDX_W'(f);
    enqueue(r);
  endtask

  task automatic send_slot(input logic [REQ_W-1:0] kind, input int idx,
                           input logic [SEXPR_W-1:0] expr, input logic [LINK_W-1:0] link);
    req_t r;
    r = random_fields();
    r.req_type   = kind;
    r.slot_index = SIDX_W'(idx);
    r.slot_expr  = expr;
    r.slot_link  = link;
    enqueue(r);
  endtask

  // Zero every lower frame, then the top one, so the last release pops all in one cascade.
  task automatic drain_stack();
    int f;
    int top;
    top = depth_m[STEER] - 1;
    for (f = 0; f < top; f++) begin
      while (uses_left_m[STEER][f] > 0) send_release(f);
    end
    while (depth_m[STEER] > 0) send_release(depth_m[STEER] - 1);
  endtask

  task automatic random_item();
    req_t r;
    int   pick;
    int   top_sz;
    int   depth;
    r = random_fields();
    depth  = depth_m[STEER];
    top_sz = (depth == 0) ? 0 : frame_len_m[STEER][depth - 1];
    pick = $urandom_range(99);
    // keep the stack shallow enough to drain cheaply
    if (pick < 22 && used_m[STEER] > USED_CAP) pick = 99;
    if (pick < 22) begin
      r.req_type = REQ_PUSH;
      pick = $urandom_range(99);
      if (pick < 8) r.claim_size = '0;
      else if (pick < 18) r.claim_size = FSIZE_W'($urandom_range(2047, SLOTS - used_m[STEER] + 1));
      else if (pick < 24) r.claim_size = FSIZE_W'($urandom_range(40, 5));
      else r.claim_size = FSIZE_W'($urandom_range(4, 1));
    end else if (pick < 55) begin
      r.req_type = (pick < 38) ? REQ_STORE : REQ_READ;
      if (top_sz > 0 && $urandom_range(99) < 85) r.slot_index = SIDX_W'($urandom_range(top_sz - 1));
    end else begin
      r.req_type = REQ_RELEASE;
      pick = $urandom_range(99);
      if (depth > 0 && pick < 85) begin
        if (pick < 50) r.frame_index = FIDX_W'(depth - 1);
        else r.frame_index = FIDX_W'($urandom_range(depth - 1));
      end else if (depth > 0 && depth < FRAMES && pick < 93) begin
        r.frame_index = FIDX_W'($urandom_range(FRAMES - 1, depth));
      end
    end
    enqueue(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("report %0d: %s got 0x%0h expected 0x%0h", report_count, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // Driver: present the oldest pending item, hold it while busy, idle at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_reports.push_back(advance_stack(CHECK, req_i));
        void'(request_queue.pop_front());
        accepted_count++;
      end
      if (accepted_count < total_items / 3) idle_pct = 23;
      else if (accepted_count < 2 * total_items / 3) idle_pct = 51;
      else idle_pct = 0;
      if (!(start && busy)) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= request_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle carries one report, compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch("unexpected report, status", 32'(rsp_o.status), 32'(ST_OK));
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", 32'(rsp_o.status), 32'(want.status));
          check_field("stack_empty", 32'(rsp_o.stack_empty), 32'(want.stack_empty));
          check_field("base_offset", 32'(rsp_o.base_offset), 32'(want.base_offset));
          check_field("top_frame_size", 32'(rsp_o.top_frame_size), 32'(want.top_frame_size));
          check_field("top_frame", 32'(rsp_o.top_frame), 32'(want.top_frame));
          check_field("used_slots", 32'(rsp_o.used_slots), 32'(want.used_slots));
          check_field("read_expr", rsp_o.read_expr, want.read_expr);
          check_field("read_link", 32'(rsp_o.read_link), 32'(want.read_link));
        end
        report_count++;
      end
    end
  end

  initial begin
    int n;
    // requests against an empty stack, then bad pushes
    send_slot(REQ_READ, 0, $urandom, '0);
    send_slot(REQ_STORE, SLOTS - 1, '1, '1);
    send_release(0);
    send_push(0);
    send_push(2047);
    send_push(SLOTS + 1);
    send_push(3);
    send_push(5);
    send_slot(REQ_STORE, 4, '1, '1);
    send_slot(REQ_READ, 4, '0, '0);
    send_slot(REQ_STORE, 0, '0, '0);
    send_slot(REQ_READ, 0, '1, '1);
    send_slot(REQ_READ, 5, $urandom, '1);
    send_slot(REQ_STORE, SLOTS - 1, $urandom, '1);
    send_release(2);
    send_release(FRAMES - 1);
    // drain the lower frame, release it once more, then pop both from the top
    repeat (4) send_release(0);
    drain_stack();

    for (n = 0; n < RANDOM_ITEMS; n++) random_item();
    drain_stack();

    // fill the frame table, overflow it, then pop every frame in one cascade
    while (depth_m[STEER] < FRAMES) send_push(1);
    send_push(1);
    drain_stack();

    // claim the whole slot memory in one frame
    send_push(SLOTS);
    send_slot(REQ_STORE, SLOTS - 1, '1, '1);
    send_slot(REQ_READ, SLOTS - 1, '0, '0);
    send_push(1);
    send_slot(REQ_READ, 0, $urandom, '0);
    send_release(FRAMES - 1);

    total_items = request_queue.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_count == total_items && awaited_reports.size() == 0)
           && quiet_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (quiet_cycles < STALL_LIMIT) repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (quiet_cycles < STALL_LIMIT && mismatch_count == 0) begin
      $display("frame_stack_deferred_release_unit: match");
    end else begin
      $display("frame_stack_deferred_release_unit: mismatch");
    end
    $finish;
  end

endmodule
